@@ hw/rtl/pwl_pkg.sv @@
// Shared types and codes for the piecewise-linear table interpolator.
// No dependencies.
package pwl_pkg;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] TBL_ELASTIC    = 2'd0;
    localparam logic [1:0] TBL_EXCITATION = 2'd1;
    localparam logic [1:0] TBL_IONIZATION = 2'd2;

    localparam logic [2:0] REG_EN_ELASTIC    = 3'd0;
    localparam logic [2:0] REG_EN_EXCITATION = 3'd1;
    localparam logic [2:0] REG_EN_IONIZATION = 3'd2;
    localparam logic [2:0] REG_THR_EXCITE    = 3'd3;
    localparam logic [2:0] REG_THR_IONIZE    = 3'd4;

    // Command kinds passed from front end to back end
    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_APPEND,
        CMD_QUERY,
        CMD_MISS
    } pwl_kind_t;

    typedef struct packed {
        pwl_kind_t   kind;
        logic [1:0]  sel;
        logic [31:0] energy;
        logic [31:0] pcs;
    } pwl_cmd_t;

endpackage

@@ hw/rtl/pwl_front.sv @@
// Front end: configuration registers, input handshake and op classification.
// Depends on pwl_pkg.
module pwl_front #(
    parameter int NUM_TABLES = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        op,
    input  logic [1:0]        table_select,
    input  logic [31:0]       energy,
    input  logic [31:0]       point_xsec,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic              q_full,
    output logic              q_push,
    output pwl_pkg::pwl_cmd_t q_cmd
);
    import pwl_pkg::*;

    logic        en_el_reg;
    logic        en_ex_reg;
    logic        en_io_reg;
    logic [31:0] thr_ex_reg;
    logic [31:0] thr_io_reg;
    logic        sel_ok;
    logic        open;
    logic        keep;
    logic        accept;

    assign cfg_ready = 1'b1;
    assign busy      = q_full;
    assign accept    = start && !busy;
    assign sel_ok    = (int'(table_select) < NUM_TABLES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_el_reg  <= 1'b1;
            en_ex_reg  <= 1'b1;
            en_io_reg  <= 1'b1;
            thr_ex_reg <= '0;
            thr_io_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_EN_ELASTIC:    en_el_reg  <= cfg_data[0];
                REG_EN_EXCITATION: en_ex_reg  <= cfg_data[0];
                REG_EN_IONIZATION: en_io_reg  <= cfg_data[0];
                REG_THR_EXCITE:    thr_ex_reg <= cfg_data;
                REG_THR_IONIZE:    thr_io_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (table_select)
            TBL_ELASTIC:    open = en_el_reg;
            TBL_EXCITATION: open = en_ex_reg && (energy >= thr_ex_reg);
            TBL_IONIZATION: open = en_io_reg && (energy >= thr_io_reg);
            default:        open = 1'b1;
        endcase
    end

    always_comb
    begin
        q_cmd.sel    = table_select;
        q_cmd.energy = energy;
        q_cmd.pcs    = point_xsec;
        q_cmd.kind   = CMD_MISS;
        keep         = 1'b0;
        unique case (op)
            OP_CLEAR:
            begin
                q_cmd.kind = CMD_CLEAR;
                keep       = sel_ok;
            end
            OP_APPEND:
            begin
                q_cmd.kind = CMD_APPEND;
                keep       = sel_ok;
            end
            OP_QUERY:
            begin
                q_cmd.kind = (sel_ok && open) ? CMD_QUERY : CMD_MISS;
                keep       = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    assign q_push = accept && keep;

endmodule

@@ hw/rtl/pwl_fifo.sv @@
// Two-entry command queue between front and back end.
// Depends on pwl_pkg.
module pwl_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pwl_pkg::pwl_cmd_t push_cmd,
    input  logic              pop,
    output pwl_pkg::pwl_cmd_t head,
    output logic              empty,
    output logic              full
);
    import pwl_pkg::*;

    pwl_cmd_t    slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg;

    assign empty = (cnt_reg == 2'd0);
    assign full  = (cnt_reg == 2'd2);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
        end
    end

endmodule

@@ hw/rtl/pwl_back.sv @@
// Back end: point stores, point counts, linear segment scan and serial divider.
// Depends on pwl_pkg.
module pwl_back #(
    parameter int TABLE_DEPTH = 512,
    parameter int NUM_TABLES  = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  pwl_pkg::pwl_cmd_t q_head,
    output logic              q_pop,
    output logic              done,
    output logic [31:0]       xsec,
    output logic              in_range
);
    import pwl_pkg::*;

    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W = $clog2(NUM_TABLES * TABLE_DEPTH);
    localparam int SEL_W  = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int WIDE_W = ADDR_W + CNT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LAST_WAIT,
        S_LAST_CHK,
        S_FIRST_WAIT,
        S_FIRST_CHK,
        S_WAIT,
        S_CHK,
        S_MUL,
        S_DIV,
        S_FIN
    } state_t;

    function automatic logic [ADDR_W-1:0] mk_addr(input logic [SEL_W-1:0] s,
                                                  input logic [CNT_W-1:0] i);
        logic [WIDE_W-1:0] t;
        t = WIDE_W'(s) * WIDE_W'(TABLE_DEPTH) + WIDE_W'(i);
        return t[ADDR_W-1:0];
    endfunction

    logic [31:0]       e_mem [NUM_TABLES * TABLE_DEPTH];
    logic [31:0]       c_mem [NUM_TABLES * TABLE_DEPTH];
    logic [CNT_W-1:0]  count_reg [NUM_TABLES];

    state_t            state_reg;
    logic [SEL_W-1:0]  sel_reg;
    logic [31:0]       energy_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [31:0]       e_rd_reg;
    logic [31:0]       c_rd_reg;
    logic [31:0]       prev_e_reg;
    logic [31:0]       prev_c_reg;
    logic [31:0]       c1_reg;
    logic              up_reg;
    logic [31:0]       mag_reg;
    logic [31:0]       d_reg;
    logic [31:0]       w_reg;
    logic [63:0]       quo_reg;
    logic [31:0]       rem_reg;
    logic [5:0]        step_reg;
    logic              done_reg;
    logic [31:0]       cs_reg;
    logic              hit_reg;

    logic [SEL_W-1:0]  head_sel;
    logic [CNT_W-1:0]  head_cnt;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [32:0]       trial;
    logic [32:0]       trial_sub;

    assign head_sel = SEL_W'(q_head.sel);
    assign head_cnt = count_reg[head_sel];
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign wr_en    = q_pop && (q_head.kind == CMD_APPEND)
                      && (head_cnt < CNT_W'(TABLE_DEPTH));
    assign wr_addr  = mk_addr(head_sel, head_cnt);

    // restoring divide step: bring down one dividend bit
    assign trial     = {rem_reg, quo_reg[63]};
    assign trial_sub = trial - {1'b0, w_reg};

    assign done     = done_reg;
    assign xsec     = cs_reg;
    assign in_range = hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            e_mem[wr_addr] <= q_head.energy;
            c_mem[wr_addr] <= q_head.pcs;
        end
        e_rd_reg <= e_mem[addr_reg];
        c_rd_reg <= c_mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            for (int t = 0; t < NUM_TABLES; t++)
            begin
                count_reg[t] <= '0;
            end
            sel_reg    <= '0;
            energy_reg <= '0;
            n_reg      <= '0;
            idx_reg    <= '0;
            addr_reg   <= '0;
            prev_e_reg <= '0;
            prev_c_reg <= '0;
            c1_reg     <= '0;
            up_reg     <= 1'b0;
            mag_reg    <= '0;
            d_reg      <= '0;
            w_reg      <= '0;
            quo_reg    <= '0;
            rem_reg    <= '0;
            step_reg   <= '0;
            done_reg   <= 1'b0;
            cs_reg     <= '0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            cs_reg   <= '0;
            hit_reg  <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        sel_reg    <= head_sel;
                        energy_reg <= q_head.energy;
                        n_reg      <= head_cnt;
                        unique case (q_head.kind)
                            CMD_CLEAR:  count_reg[head_sel] <= '0;
                            CMD_APPEND:
                            begin
                                if (wr_en)
                                begin
                                    count_reg[head_sel] <= head_cnt + 1'b1;
                                end
                            end
                            CMD_QUERY:
                            begin
                                // fewer than two points: no segment to match
                                if (head_cnt < CNT_W'(2))
                                begin
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    addr_reg  <= mk_addr(head_sel, head_cnt - 1'b1);
                                    state_reg <= S_LAST_WAIT;
                                end
                            end
                            default: done_reg <= 1'b1;
                        endcase
                    end
                end
                S_LAST_WAIT:
                begin
                    state_reg <= S_LAST_CHK;
                end
                S_LAST_CHK:
                begin
                    if (energy_reg > e_rd_reg)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        addr_reg  <= mk_addr(sel_reg, '0);
                        state_reg <= S_FIRST_WAIT;
                    end
                end
                S_FIRST_WAIT:
                begin
                    state_reg <= S_FIRST_CHK;
                end
                S_FIRST_CHK:
                begin
                    if (energy_reg < e_rd_reg)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        prev_e_reg <= e_rd_reg;
                        prev_c_reg <= c_rd_reg;
                        idx_reg    <= CNT_W'(1);
                        addr_reg   <= mk_addr(sel_reg, CNT_W'(1));
                        state_reg  <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if ((energy_reg >= prev_e_reg) && (energy_reg <= e_rd_reg))
                    begin
                        c1_reg  <= prev_c_reg;
                        up_reg  <= (c_rd_reg >= prev_c_reg);
                        mag_reg <= (c_rd_reg >= prev_c_reg) ? (c_rd_reg - prev_c_reg)
                                                            : (prev_c_reg - c_rd_reg);
                        d_reg   <= energy_reg - prev_e_reg;
                        w_reg   <= e_rd_reg - prev_e_reg;
                        // zero-width segment gives its left value
                        if (e_rd_reg == prev_e_reg)
                        begin
                            done_reg  <= 1'b1;
                            hit_reg   <= 1'b1;
                            cs_reg    <= prev_c_reg;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_MUL;
                        end
                    end
                    else if (idx_reg == n_reg - 1'b1)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        prev_e_reg <= e_rd_reg;
                        prev_c_reg <= c_rd_reg;
                        idx_reg    <= idx_reg + 1'b1;
                        addr_reg   <= mk_addr(sel_reg, idx_reg + 1'b1);
                        state_reg  <= S_WAIT;
                    end
                end
                S_MUL:
                begin
                    quo_reg   <= 64'(mag_reg) * 64'(d_reg);
                    rem_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (!trial_sub[32])
                    begin
                        rem_reg <= trial_sub[31:0];
                        quo_reg <= {quo_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= trial[31:0];
                        quo_reg <= {quo_reg[62:0], 1'b0};
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 6'd63)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    done_reg  <= 1'b1;
                    hit_reg   <= 1'b1;
                    cs_reg    <= up_reg ? (c1_reg + quo_reg[31:0]) : (c1_reg - quo_reg[31:0]);
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ hw/rtl/piecewise_linear_table_interpolator.sv @@
// Top level of the piecewise-linear table interpolator.
// Depends on pwl_pkg, pwl_front, pwl_fifo, pwl_back.
// Usage:
//   Items enter on start/busy: a transaction completes at a rising edge with
//   start high and busy low. op selects clear, append or query of the table
//   named by table_select. Only queries produce a result.
//   A result appears for one cycle with done high, on xsec and in_range;
//   the receiver cannot stall it, so it must take it then.
//   Registers are written through cfg_valid/cfg_ready (cfg_ready is always
//   high), at index cfg_index with cfg_data. The user must write them only
//   while no item is in flight; the block itself does not enforce this.
// Sequencing: a command leaves the two-entry queue in the cycle after its
//   acceptance when the back end is idle; busy is high while the queue is full.
//   Clear and append take effect at the edge the command leaves the queue.
//   A query that hits segment k first scans the segments up to k through the
//   single read port, a wait state and a check state each, then runs the
//   restoring divider; a zero-width segment skips the divider. Misses end
//   before the scan, or after a full scan of n points.
// Reset: rst_n clears point counts and control state, sets enables to 1 and
//   thresholds to 0; the point stores are not cleared.
module piecewise_linear_table_interpolator #(
    parameter int TABLE_DEPTH = 512,
    parameter int NUM_TABLES  = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [1:0]  table_select,
    input  logic [31:0] energy,
    input  logic [31:0] point_xsec,
    output logic        done,
    output logic [31:0] xsec,
    output logic        in_range,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import pwl_pkg::*;

    pwl_cmd_t push_cmd;
    pwl_cmd_t head_cmd;
    logic     push;
    logic     pop;
    logic     q_empty;
    logic     q_full;

    pwl_front #(
        .NUM_TABLES (NUM_TABLES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .table_select (table_select),
        .energy       (energy),
        .point_xsec   (point_xsec),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_full       (q_full),
        .q_push       (push),
        .q_cmd        (push_cmd)
    );

    pwl_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    pwl_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NUM_TABLES  (NUM_TABLES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (head_cmd),
        .q_pop    (pop),
        .done     (done),
        .xsec     (xsec),
        .in_range (in_range)
    );

endmodule

@@ hw/rtl/pwl_checker.sv @@
// Port-level checks for the piecewise-linear table interpolator.
// Bound to piecewise_linear_table_interpolator; no other dependencies.
module pwl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [31:0] xsec,
    input logic        in_range
);

    // outputs are quiet between results
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> (!in_range && (xsec == 32'd0)))
        else $error("result ports active without done");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !in_range) |-> (xsec == 32'd0))
        else $error("miss result carries nonzero cross section");

    // queue can only fill up through an accepted transaction
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> !busy)
        else $error("busy rose without a transaction");

endmodule

bind piecewise_linear_table_interpolator pwl_checker u_pwl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .xsec     (xsec),
    .in_range (in_range)
);

@@ dv/tb_piecewise_linear_table_interpolator.sv @@
// Self-checking testbench for piecewise_linear_table_interpolator.
// Depends on pwl_pkg and the RTL top level; a built-in table model predicts
// every query result, which the monitor checks in order.
`timescale 1ns / 1ps

module tb_piecewise_linear_table_interpolator;
    import pwl_pkg::*;

    localparam int DEPTH      = 512;
    localparam int TABLES     = 3;
    localparam int WATCHDOG   = 20000;
    localparam int SETTLE     = 20;

    typedef struct {
        logic [1:0]  op;
        logic [1:0]  sel;
        logic [31:0] energy;
        logic [31:0] pcs;
    } pwl_item_t;

    typedef struct {
        logic [31:0] xs;
        logic        hit;
    } xs_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  op;
    logic [1:0]  table_select;
    logic [31:0] energy;
    logic [31:0] point_xsec;
    logic        done;
    logic [31:0] xsec;
    logic        in_range;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    piecewise_linear_table_interpolator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .table_select (table_select),
        .energy       (energy),
        .point_xsec   (point_xsec),
        .done         (done),
        .xsec         (xsec),
        .in_range     (in_range),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Table model state
    logic [31:0] model_energy [TABLES][DEPTH];
    logic [31:0] model_xs [TABLES][DEPTH];
    int          model_count [TABLES];
    logic        en_elastic;
    logic        en_excitation;
    logic        en_ionization;
    logic [31:0] thr_excitation;
    logic [31:0] thr_ionization;

    pwl_item_t   pending_items[$];
    xs_result_t  expected_xs[$];
    int          sender_idle_pct;
    logic        took;
    int          errors;
    int          quiet_cycles;
    int          n_items;
    int          n_queries;
    int          n_hits;
    int          n_cfg;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // First bracketing segment, linear interpolation with truncated quotient
    function automatic logic interpolate(int t, logic [31:0] e, output logic [31:0] v);
        int          n;
        logic [31:0] e1;
        logic [31:0] e2;
        logic [31:0] c1;
        logic [31:0] c2;
        logic [63:0] mag;
        logic [63:0] q;
        n = model_count[t];
        v = '0;
        if (n == 0 || e < model_energy[t][0] || e > model_energy[t][n-1])
            return 1'b0;
        for (int i = 0; i + 1 < n; i++)
        begin
            e1 = model_energy[t][i];
            e2 = model_energy[t][i+1];
            if (e >= e1 && e <= e2)
            begin
                c1 = model_xs[t][i];
                c2 = model_xs[t][i+1];
                if (e2 == e1)
                begin
                    v = c1;
                    return 1'b1;
                end
                mag = (c2 >= c1) ? {32'd0, c2 - c1} : {32'd0, c1 - c2};
                q = (mag * {32'd0, e - e1}) / {32'd0, e2 - e1};
                v = (c2 >= c1) ? c1 + q[31:0] : c1 - q[31:0];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic xs_result_t predict_query(logic [1:0] sel, logic [31:0] e);
        xs_result_t r;
        logic       open;
        r.xs  = '0;
        r.hit = 1'b0;
        case (sel)
            TBL_ELASTIC:    open = en_elastic;
            TBL_EXCITATION: open = en_excitation && e >= thr_excitation;
            TBL_IONIZATION: open = en_ionization && e >= thr_ionization;
            default:        open = 1'b0;
        endcase
        if (open)
            r.hit = interpolate(int'(sel), e, r.xs);
        if (!r.hit)
            r.xs = '0;
        return r;
    endfunction

    // Driver: one nonblocking update of start per falling edge
    always @(negedge clk)
    begin
        logic      next_start;
        pwl_item_t it;
        next_start = start;
        if (!rst_n)
            next_start = 1'b0;
        else if (!start || took)
        begin
            next_start = 1'b0;
            if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                it = pending_items.pop_front();
                op           <= it.op;
                table_select <= it.sel;
                energy       <= it.energy;
                point_xsec   <= it.pcs;
                next_start = 1'b1;
            end
        end
        start <= next_start;
    end

    // Monitor: transactions, register writes and result checks
    always @(posedge clk)
    begin
        xs_result_t exp_r;
        int         t;
        logic       active;
        active = 1'b0;
        if (rst_n)
        begin
            took <= start && !busy;
            if (done)
            begin
                active = 1'b1;
                if (expected_xs.size() == 0)
                begin
                    $display("%0t: result with none expected: xsec %h in_range %b",
                             $time, xsec, in_range);
                    errors++;
                end
                else
                begin
                    exp_r = expected_xs.pop_front();
                    if (xsec !== exp_r.xs)
                    begin
                        $display("%0t: xsec expected %h actual %h",
                                 $time, exp_r.xs, xsec);
                        errors++;
                    end
                    if (in_range !== exp_r.hit)
                    begin
                        $display("%0t: in_range expected %b actual %b",
                                 $time, exp_r.hit, in_range);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                active = 1'b1;
                n_items++;
                t = int'(table_select);
                case (op)
                    OP_CLEAR:
                        if (t < TABLES)
                            model_count[t] = 0;
                    OP_APPEND:
                        if (t < TABLES && model_count[t] < DEPTH)
                        begin
                            model_energy[t][model_count[t]] = energy;
                            model_xs[t][model_count[t]] = point_xsec;
                            model_count[t]++;
                        end
                    OP_QUERY:
                    begin
                        exp_r = predict_query(table_select, energy);
                        expected_xs.push_back(exp_r);
                        n_queries++;
                        if (exp_r.hit)
                            n_hits++;
                    end
                    default: ;
                endcase
            end
            if (cfg_valid && cfg_ready)
            begin
                active = 1'b1;
                n_cfg++;
                case (cfg_index)
                    REG_EN_ELASTIC:    en_elastic = cfg_data[0];
                    REG_EN_EXCITATION: en_excitation = cfg_data[0];
                    REG_EN_IONIZATION: en_ionization = cfg_data[0];
                    REG_THR_EXCITE:    thr_excitation = cfg_data;
                    REG_THR_IONIZE:    thr_ionization = cfg_data;
                    default: ;
                endcase
            end
            quiet_cycles = active ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic push_item(logic [1:0] o, logic [1:0] s, logic [31:0] e, logic [31:0] c);
        pwl_item_t it;
        it.op = o;
        it.sel = s;
        it.energy = e;
        it.pcs = c;
        pending_items.push_back(it);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Hold off until the block has answered everything, then let it settle
    task automatic drain();
        while (pending_items.size() > 0 || start || expected_xs.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apply_setting(int k);
        logic [2:0]  ens;
        logic [31:0] te;
        logic [31:0] ti;
        if (k == 0)
        begin
            ens = 3'b111;
            te = '0;
            ti = '0;
        end
        else if (k == 1)
        begin
            ens = 3'b000;
            te = '1;
            ti = '1;
        end
        else
        begin
            ens = 3'($urandom_range(3, 7));
            te = $urandom;
            ti = $urandom;
        end
        write_reg(REG_EN_ELASTIC, {31'd0, ens[0]});
        write_reg(REG_EN_EXCITATION, {31'd0, ens[1]});
        write_reg(REG_EN_IONIZATION, {31'd0, ens[2]});
        write_reg(REG_THR_EXCITE, te);
        write_reg(REG_THR_IONIZE, ti);
    endtask

    // Clear a table, load a non-decreasing curve, then query around it
    task automatic push_curve();
        logic [1:0]  t;
        logic [31:0] pts [16];
        logic [31:0] e;
        logic [32:0] nxt;
        int          n;
        int          k;
        t = 2'($urandom_range(2));
        n = ($urandom_range(9) == 0) ? int'($urandom_range(1)) : int'($urandom_range(2, 16));
        push_item(OP_CLEAR, t, $urandom, $urandom);
        e = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 32'h00ff_ffff);
        for (int i = 0; i < n; i++)
        begin
            pts[i] = e;
            push_item(OP_APPEND, t, e, $urandom);
            nxt = {1'b0, e} + ($urandom_range(4) == 0 ? 33'd0
                  : 33'($urandom_range(1, 1 << $urandom_range(0, 24))));
            e = nxt[32] ? 32'hffff_ffff : nxt[31:0];
        end
        k = int'($urandom_range(2, 6));
        for (int i = 0; i < k; i++)
        begin
            case ($urandom_range(4))
                0: e = (n > 0) ? pts[$urandom_range(n - 1)] : $urandom;
                1: e = (n > 0) ? pts[0] - 32'd1 : $urandom;
                2: e = (n > 0) ? pts[n-1] + 32'd1 : $urandom;
                3: e = $urandom;
                default: e = (n > 1) ? $urandom_range(pts[0], pts[n-1]) : $urandom;
            endcase
            push_item(OP_QUERY, t, e, $urandom);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_CLEAR;
        table_select = TBL_ELASTIC;
        energy = '0;
        point_xsec = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_EN_ELASTIC;
        cfg_data = '0;
        took = 1'b0;
        errors = 0;
        quiet_cycles = 0;
        n_items = 0;
        n_queries = 0;
        n_hits = 0;
        n_cfg = 0;
        sender_idle_pct = 0;
        for (int i = 0; i < TABLES; i++)
            model_count[i] = 0;
        en_elastic = 1'b1;
        en_excitation = 1'b1;
        en_ionization = 1'b1;
        thr_excitation = '0;
        thr_ionization = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty, bad table, op three, single point, zero width, extremes
        push_item(OP_QUERY, TBL_ELASTIC, 32'd0, 32'd0);
        push_item(OP_APPEND, 2'd3, 32'h10, 32'h20);
        push_item(OP_QUERY, 2'd3, 32'h10, 32'd0);
        push_item(2'd3, TBL_ELASTIC, '1, '1);
        push_item(OP_APPEND, TBL_ELASTIC, 32'd0, 32'hffff_ffff);
        push_item(OP_QUERY, TBL_ELASTIC, 32'd0, 32'd0);
        push_item(OP_APPEND, TBL_ELASTIC, 32'd0, 32'd5);
        push_item(OP_QUERY, TBL_ELASTIC, 32'd0, 32'd0);
        push_item(OP_APPEND, TBL_ELASTIC, 32'hffff_ffff, 32'd0);
        push_item(OP_QUERY, TBL_ELASTIC, 32'hffff_ffff, 32'd0);
        push_item(OP_QUERY, TBL_ELASTIC, 32'h8000_0000, 32'd0);
        push_item(OP_APPEND, TBL_EXCITATION, 32'd100, 32'd10);
        push_item(OP_APPEND, TBL_EXCITATION, 32'd200, 32'd1000);
        push_item(OP_QUERY, TBL_EXCITATION, 32'd150, 32'd0);
        push_item(OP_QUERY, TBL_EXCITATION, 32'd99, 32'd0);
        push_item(OP_QUERY, TBL_EXCITATION, 32'd201, 32'd0);
        push_item(OP_APPEND, TBL_IONIZATION, 32'd100, 32'd7);
        push_item(OP_APPEND, TBL_IONIZATION, 32'd500, 32'd9);
        push_item(OP_APPEND, TBL_IONIZATION, 32'd300, 32'd3);
        push_item(OP_QUERY, TBL_IONIZATION, 32'd400, 32'd0);
        push_item(OP_QUERY, TBL_IONIZATION, 32'd300, 32'd0);
        push_item(OP_CLEAR, TBL_EXCITATION, 32'd0, 32'd0);
        push_item(OP_QUERY, TBL_EXCITATION, 32'd150, 32'd0);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            int target;
            sender_idle_pct = (ph < 2) ? 14 : (ph < 4) ? 47 : 0;
            apply_setting(ph);
            target = pending_items.size() + 200;
            if (ph == 2)
            begin
                // Fill one table past its depth; appends beyond it are dropped
                push_item(OP_CLEAR, TBL_ELASTIC, '0, '0);
                for (int i = 0; i < DEPTH + 3; i++)
                    push_item(OP_APPEND, TBL_ELASTIC, 32'(i * 1000), $urandom);
                push_item(OP_QUERY, TBL_ELASTIC, 32'((DEPTH - 1) * 1000), '0);
                push_item(OP_QUERY, TBL_ELASTIC, 32'((DEPTH - 1) * 1000 + 1), '0);
                push_item(OP_QUERY, TBL_ELASTIC, 32'd123_456, '0);
                push_item(OP_CLEAR, TBL_ELASTIC, '0, '0);
            end
            while (pending_items.size() < target)
            begin
                if ($urandom_range(99) < 15)
                    push_item(2'($urandom), 2'($urandom), $urandom, $urandom);
                else
                    push_curve();
            end
            drain();
        end

        $display("Covered %0d transactions: %0d queries (%0d in range), %0d register writes,",
                 n_items, n_queries, n_hits, n_cfg);
        $display("across six enable/threshold settings with varied sender gaps.");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
